/* rtl/tpd_pkg.sv */
`timescale 1ns / 1ps
package tpd_pkg;

  localparam int DIST_BITS = 48;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_EDGE  = 2'd1,
    OP_BUILD = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_NODE  = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_BUILT = 2'd3;

  typedef struct packed {
    op_t         op;
    logic [15:0] node_a;
    logic [15:0] node_b;
    logic [31:0] edge_length;
    logic [16:0] node_count;
  } item_t;

  typedef struct packed {
    logic [DIST_BITS-1:0] path_length;
    logic [1:0]           status;
  } result_t;

endpackage

/* rtl/tpd_ram.sv */
`timescale 1ns / 1ps
module tpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/tree_path_distance_lca.sv */
`timescale 1ns / 1ps
// Channel | Direction | Handshake               | Word
// item    | in        | item_valid / item_ready | item_t: op, nodes, length, count
// result  | out       | result_valid / result_ready | result_t: path_length, status
// cfg     | in        | cfg_valid / cfg_ready   | root_node (16 bit)
//
// One word at a time: a new item is taken only once the last word is finished.
// Clear: one pass over the node store.
// Build: a pass that clears the reached marks, the root seated on every lift level,
// then a depth-first walk that fills the jump table for each newly reached node and
// passes over each edge that meets a node already reached. Add edge: each direction
// is appended to its source node's list. Query: the deeper node is lifted by the set
// bits of the depth gap, then both climb from the top level down when they differ,
// through the single read port of the jump table. Words refused on entry go straight out.
// Reset is synchronous; after it no node is in use, so nothing reads the stores
// before a clear has swept them. A finished word waits in the output register.
module tree_path_distance_lca
  import tpd_pkg::*;
#(
  parameter int MAX_NODES   = 65536,
  parameter int LIFT_LEVELS = 16,
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_ready,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int NW = $clog2(MAX_NODES);
  localparam int EC = 2 * MAX_NODES;
  localparam int EW = $clog2(EC);
  localparam int LW = EW + 1;                 // list link: edge index + 1, 0 = end
  localparam int DW = NW + 1;
  localparam int KW = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
  localparam int JD = (2 ** KW) * (2 ** NW);
  localparam int IW = 1 + DW + DIST_BITS;     // reached, depth, root distance
  localparam int SW = NW + LW;                // stack entry: node, next link

  typedef enum logic [26:0] {
    S_IDLE    = 27'd1 << 0,
    S_SWEEP   = 27'd1 << 1,
    S_ADD_RD  = 27'd1 << 2,
    S_ADD_WR  = 27'd1 << 3,
    S_ROOT_HD = 27'd1 << 4,
    S_ROOT_J  = 27'd1 << 5,
    S_TOP     = 27'd1 << 6,
    S_LINK    = 27'd1 << 7,
    S_EDGE    = 27'd1 << 8,
    S_CHKV    = 27'd1 << 9,
    S_NEWV    = 27'd1 << 10,
    S_JRD     = 27'd1 << 11,
    S_JWR     = 27'd1 << 12,
    S_PUSH    = 27'd1 << 13,
    S_PUSHW   = 27'd1 << 14,
    S_QRB     = 27'd1 << 15,
    S_QCHK    = 27'd1 << 16,
    S_LIFT    = 27'd1 << 17,
    S_LIFTW   = 27'd1 << 18,
    S_EQ      = 27'd1 << 19,
    S_UPA     = 27'd1 << 20,
    S_UPB     = 27'd1 << 21,
    S_UPC     = 27'd1 << 22,
    S_LCA     = 27'd1 << 23,
    S_LCAW    = 27'd1 << 24,
    S_DIST    = 27'd1 << 25,
    S_DONE    = 27'd1 << 26
  } state_t;

  state_t state, state_next;

  // architectural registers
  logic [15:0]   root_node;
  logic [NW:0]   nodes_in_use;
  logic [LW-1:0] edges_stored;
  logic          built;

  // working registers
  op_t                   op_q;
  logic [NW-1:0]         na, nb, u, v, cur, pu;
  logic [LENGTH_BITS-1:0] wt;
  logic [NW:0]           cnt, sp;
  logic                  half;
  logic [KW:0]           k;
  logic [DW-1:0]         dep_a;
  logic [DIST_BITS-1:0]  dist_a, dsum, pl;
  logic [LIFT_LEVELS-1:0] dd;
  logic [1:0]            st;

  // memory ports
  logic                  head_we, tail_we, e_we, nxt_we, info_we, jmp_we, stk_we;
  logic [NW-1:0]         head_wa, head_ra, tail_wa, tail_ra, info_wa, info_ra;
  logic [NW-1:0]         stk_wa, stk_ra;
  logic [LW-1:0]         head_wd, tail_wd, nxt_wd, head_q, tail_q, nxt_q;
  logic [EW-1:0]         e_wa, e_ra, nxt_wa;
  logic [NW-1:0]         tgt_wd, tgt_q, jmp_wd, jmp_q;
  logic [LENGTH_BITS-1:0] wgt_q;
  logic [IW-1:0]         info_wd, info_q;
  logic [KW+NW-1:0]      jmp_wa, jmp_ra;
  logic [SW-1:0]         stk_wd, stk_q;

  tpd_ram #(.WIDTH(LW), .DEPTH(MAX_NODES)) u_head (
    .clk, .we(head_we), .waddr(head_wa), .wdata(head_wd), .raddr(head_ra), .rdata(head_q));
  tpd_ram #(.WIDTH(LW), .DEPTH(MAX_NODES)) u_tail (
    .clk, .we(tail_we), .waddr(tail_wa), .wdata(tail_wd), .raddr(tail_ra), .rdata(tail_q));
  tpd_ram #(.WIDTH(NW), .DEPTH(EC)) u_tgt (
    .clk, .we(e_we), .waddr(e_wa), .wdata(tgt_wd), .raddr(e_ra), .rdata(tgt_q));
  tpd_ram #(.WIDTH(LENGTH_BITS), .DEPTH(EC)) u_wgt (
    .clk, .we(e_we), .waddr(e_wa), .wdata(wt), .raddr(e_ra), .rdata(wgt_q));
  tpd_ram #(.WIDTH(LW), .DEPTH(EC)) u_nxt (
    .clk, .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd), .raddr(e_ra), .rdata(nxt_q));
  tpd_ram #(.WIDTH(IW), .DEPTH(MAX_NODES)) u_info (
    .clk, .we(info_we), .waddr(info_wa), .wdata(info_wd), .raddr(info_ra), .rdata(info_q));
  tpd_ram #(.WIDTH(NW), .DEPTH(JD)) u_jump (
    .clk, .we(jmp_we), .waddr(jmp_wa), .wdata(jmp_wd), .raddr(jmp_ra), .rdata(jmp_q));
  tpd_ram #(.WIDTH(SW), .DEPTH(MAX_NODES)) u_stack (
    .clk, .we(stk_we), .waddr(stk_wa), .wdata(stk_wd), .raddr(stk_ra), .rdata(stk_q));

  // fields of the word read back from the node store
  logic                 info_reached;
  logic [DW-1:0]        info_depth;
  logic [DIST_BITS-1:0] info_dist;
  assign info_reached = info_q[IW-1];
  assign info_depth   = info_q[IW-2 -: DW];
  assign info_dist    = info_q[DIST_BITS-1:0];

  // stack entry read back
  logic [NW-1:0] stk_node;
  logic [LW-1:0] stk_link;
  assign stk_node = stk_q[SW-1 -: NW];
  assign stk_link = stk_q[LW-1:0];

  logic          accept;
  logic [NW-1:0] item_a, item_b, from_n, to_n, root_n;
  logic          a_ok, b_ok, cnt_bad, store_full, root_bad, d_less;
  logic [LW-1:0] link_new;
  logic [DW-1:0] depth_gap;

  assign item_ready = (state == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign accept     = item_valid && item_ready;

  assign item_a     = NW'(item.node_a);
  assign item_b     = NW'(item.node_b);
  assign root_n     = NW'(root_node);
  assign a_ok       = 32'(item.node_a) < 32'(nodes_in_use);
  assign b_ok       = 32'(item.node_b) < 32'(nodes_in_use);
  assign cnt_bad    = (item.node_count == '0) || (32'(item.node_count) > MAX_NODES);
  assign store_full = (32'(edges_stored) + 32'd2) > EC;
  assign root_bad   = 32'(root_node) >= 32'(nodes_in_use);
  assign from_n     = half ? nb : na;
  assign to_n       = half ? na : nb;
  assign link_new   = edges_stored + 1'b1;
  assign d_less     = dep_a < info_depth;
  assign depth_gap  = d_less ? (info_depth - dep_a) : (dep_a - info_depth);

  // both query nodes were reached by the last build
  logic ra_q;
  function automatic logic dep_reached_ok();
    return ra_q && info_reached;
  endfunction

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (item.op)
            OP_CLEAR: state_next = cnt_bad ? S_DONE : S_SWEEP;
            OP_EDGE:  state_next = (!a_ok || !b_ok || store_full) ? S_DONE : S_ADD_RD;
            OP_BUILD: state_next = root_bad ? S_DONE : S_SWEEP;
            OP_QUERY: state_next = (!a_ok || !b_ok || !built) ? S_DONE : S_QRB;
            default:  state_next = S_DONE;
          endcase
        end
      end
      S_SWEEP: begin
        if (cnt == (NW+1)'(MAX_NODES - 1)) begin
          state_next = (op_q == OP_CLEAR) ? S_DONE : S_ROOT_HD;
        end
      end
      S_ADD_RD:  state_next = S_ADD_WR;
      S_ADD_WR:  state_next = half ? S_DONE : S_ADD_RD;
      S_ROOT_HD: state_next = S_ROOT_J;
      S_ROOT_J: begin
        if (k == (KW+1)'(LIFT_LEVELS - 1)) begin
          state_next = S_TOP;
        end
      end
      S_TOP: state_next = S_LINK;
      S_LINK: begin
        if (stk_link != '0) begin
          state_next = S_EDGE;
        end else if (sp == (NW+1)'(1)) begin
          state_next = S_DONE;
        end else begin
          state_next = S_TOP;
        end
      end
      S_EDGE:  state_next = S_CHKV;
      S_CHKV:  state_next = info_reached ? S_TOP : S_NEWV;
      S_NEWV:  state_next = (LIFT_LEVELS == 1) ? S_PUSH : S_JRD;
      S_JRD:   state_next = S_JWR;
      S_JWR:   state_next = (k == (KW+1)'(LIFT_LEVELS - 1)) ? S_PUSH : S_JRD;
      S_PUSH:  state_next = S_PUSHW;
      S_PUSHW: state_next = S_TOP;
      S_QRB:   state_next = S_QCHK;
      S_QCHK:  state_next = (!dep_reached_ok()) ? S_DONE : S_LIFT;
      S_LIFT: begin
        if (k == (KW+1)'(LIFT_LEVELS)) begin
          state_next = S_EQ;
        end else if (dd[0]) begin
          state_next = S_LIFTW;
        end
      end
      S_LIFTW: state_next = S_LIFT;
      S_EQ:    state_next = (u == v) ? S_DIST : S_UPA;
      S_UPA:   state_next = S_UPB;
      S_UPB:   state_next = S_UPC;
      S_UPC:   state_next = (k == '0) ? S_LCA : S_UPA;
      S_LCA:   state_next = S_LCAW;
      S_LCAW:  state_next = S_DIST;
      S_DIST:  state_next = S_DONE;
      S_DONE:  state_next = (!result_valid || result_ready) ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    head_we = 1'b0; head_wa = '0; head_wd = '0; head_ra = '0;
    tail_we = 1'b0; tail_wa = '0; tail_wd = '0; tail_ra = '0;
    e_we    = 1'b0; e_wa    = '0; tgt_wd  = '0; e_ra    = '0;
    nxt_we  = 1'b0; nxt_wa  = '0; nxt_wd  = '0;
    info_we = 1'b0; info_wa = '0; info_wd = '0; info_ra = '0;
    jmp_we  = 1'b0; jmp_wa  = '0; jmp_wd  = '0; jmp_ra  = '0;
    stk_we  = 1'b0; stk_wa  = '0; stk_wd  = '0; stk_ra  = '0;
    case (state)
      S_IDLE: info_ra = item_a;
      S_SWEEP: begin
        head_we = (op_q == OP_CLEAR);
        tail_we = (op_q == OP_CLEAR);
        head_wa = cnt[NW-1:0];
        tail_wa = cnt[NW-1:0];
        info_we = 1'b1;
        info_wa = cnt[NW-1:0];
      end
      S_ADD_RD: begin
        e_we    = 1'b1;
        e_wa    = edges_stored[EW-1:0];
        tgt_wd  = to_n;
        nxt_we  = 1'b1;
        nxt_wa  = edges_stored[EW-1:0];
        tail_ra = from_n;
      end
      S_ADD_WR: begin
        if (tail_q == '0) begin
          head_we = 1'b1;
          head_wa = from_n;
          head_wd = link_new;
        end else begin
          nxt_we = 1'b1;
          nxt_wa = EW'(tail_q - 1'b1);
          nxt_wd = link_new;
        end
        tail_we = 1'b1;
        tail_wa = from_n;
        tail_wd = link_new;
      end
      S_ROOT_HD: begin
        head_ra = root_n;
        info_we = 1'b1;
        info_wa = root_n;
        info_wd = {1'b1, DW'(1), DIST_BITS'(0)};
      end
      S_ROOT_J: begin
        jmp_we = 1'b1;
        jmp_wa = {k[KW-1:0], root_n};
        jmp_wd = root_n;
        if (k == '0) begin
          stk_we = 1'b1;
          stk_wa = '0;
          stk_wd = {root_n, head_q};
        end
      end
      S_TOP:  stk_ra = NW'(sp - 1'b1);
      S_LINK: e_ra   = EW'(stk_link - 1'b1);
      S_EDGE: begin
        stk_we  = 1'b1;
        stk_wa  = NW'(sp - 1'b1);
        stk_wd  = {u, nxt_q};
        info_ra = tgt_q;
      end
      S_CHKV: info_ra = u;
      S_NEWV: begin
        info_we = 1'b1;
        info_wa = v;
        info_wd = {1'b1, info_depth + 1'b1, info_dist + DIST_BITS'(wt)};
        jmp_we  = 1'b1;
        jmp_wa  = {KW'(0), v};
        jmp_wd  = u;
      end
      S_JRD: jmp_ra = {KW'(k - 1'b1), cur};
      S_JWR: begin
        jmp_we = 1'b1;
        jmp_wa = {k[KW-1:0], v};
        jmp_wd = jmp_q;
      end
      S_PUSH: head_ra = v;
      S_PUSHW: begin
        stk_we = (32'(sp) < MAX_NODES);
        stk_wa = sp[NW-1:0];
        stk_wd = {v, head_q};
      end
      S_QRB: info_ra = nb;
      S_LIFT: jmp_ra = {k[KW-1:0], u};
      S_EQ:   info_ra = u;
      S_UPA:  jmp_ra = {k[KW-1:0], u};
      S_UPB:  jmp_ra = {k[KW-1:0], v};
      S_LCA:  jmp_ra = {KW'(0), u};
      S_LCAW: info_ra = jmp_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      root_node    <= 16'd1;
      nodes_in_use <= '0;
      edges_stored <= '0;
      built        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        root_node <= cfg_data;
      end
      // a finished word goes out once the output register is free
      if (state == S_DONE && (!result_valid || result_ready)) begin
        result_valid       <= 1'b1;
        result.path_length <= pl;
        result.status      <= st;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_q <= item.op;
            na   <= item_a;
            nb   <= item_b;
            wt   <= LENGTH_BITS'(item.edge_length);
            cnt  <= '0;
            half <= 1'b0;
            pl   <= '0;
            case (item.op)
              OP_CLEAR: begin
                if (cnt_bad) begin
                  st <= ST_BAD_NODE;
                end else begin
                  st           <= ST_OK;
                  nodes_in_use <= (NW+1)'(item.node_count);
                  edges_stored <= '0;
                  built        <= 1'b0;
                end
              end
              OP_EDGE: begin
                if (!a_ok || !b_ok) begin
                  st <= ST_BAD_NODE;
                end else if (store_full) begin
                  st <= ST_FULL;
                end else begin
                  st <= ST_OK;
                end
              end
              OP_BUILD: begin
                if (root_bad) begin
                  st <= ST_BAD_NODE;
                end else begin
                  st <= ST_OK;
                end
              end
              OP_QUERY: begin
                if (!a_ok || !b_ok) begin
                  st <= ST_BAD_NODE;
                end else if (!built) begin
                  st <= ST_NOT_BUILT;
                end else begin
                  st <= ST_OK;
                end
              end
              default: st <= ST_OK;
            endcase
          end
        end
        S_SWEEP: begin
          cnt <= cnt + 1'b1;
          k   <= '0;
        end
        S_ADD_WR: begin
          edges_stored <= link_new;
          half         <= 1'b1;
          if (half) begin
            built <= 1'b0;
          end
        end
        S_ROOT_J: begin
          k  <= k + 1'b1;
          sp <= (NW+1)'(1);
        end
        S_LINK: begin
          u <= stk_node;
          if (stk_link == '0) begin
            sp <= sp - 1'b1;
            if (sp == (NW+1)'(1)) begin
              built <= 1'b1;
            end
          end
        end
        S_EDGE: begin
          v  <= tgt_q;
          wt <= wgt_q;
        end
        S_NEWV: begin
          cur <= u;
          k   <= (KW+1)'(1);
        end
        S_JWR: begin
          cur <= jmp_q;
          k   <= k + 1'b1;
        end
        S_PUSHW: begin
          if (32'(sp) < MAX_NODES) begin
            sp <= sp + 1'b1;
          end
        end
        S_QRB: begin
          ra_q   <= info_reached;
          dep_a  <= info_depth;
          dist_a <= info_dist;
        end
        S_QCHK: begin
          if (!dep_reached_ok()) begin
            st <= ST_NOT_BUILT;
          end
          dsum <= dist_a + info_dist;
          dd   <= LIFT_LEVELS'(depth_gap);
          u    <= d_less ? nb : na;
          v    <= d_less ? na : nb;
          k    <= '0;
        end
        S_LIFT: begin
          if (k != (KW+1)'(LIFT_LEVELS) && !dd[0]) begin
            k  <= k + 1'b1;
            dd <= dd >> 1;
          end
        end
        S_LIFTW: begin
          u  <= jmp_q;
          k  <= k + 1'b1;
          dd <= dd >> 1;
        end
        S_EQ: k <= (KW+1)'(LIFT_LEVELS - 1);
        S_UPB: pu <= jmp_q;
        S_UPC: begin
          if (pu != jmp_q) begin
            u <= pu;
            v <= jmp_q;
          end
          k <= k - 1'b1;
        end
        S_DIST: pl <= dsum - {info_dist[DIST_BITS-2:0], 1'b0};
        default: ;
      endcase
    end
  end

endmodule

/* rtl/tpd_check.sv */
`timescale 1ns / 1ps
module tpd_check
  import tpd_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_ready,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  // a held result word must not change
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

  // one word in flight: busy straight after an accepted item
  a_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item taken while another is in work");

  // a new result only comes from work in progress
  a_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(!item_ready))
    else $error("result appeared with no item in work");

  // failed words carry no length
  a_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != ST_OK |-> result.path_length == '0)
    else $error("nonzero length with error status");

endmodule

bind tree_path_distance_lca tpd_check u_check (.*);

/* bench/tree_path_distance_lca_test.sv */
`timescale 1ns / 1ps
// Bench for the weighted tree path-length block.
//
// Each phase clears the store, grows a tree (with some spare cycle-making and
// self-loop edges), builds the lifting tables and then fires path queries.
// A predictor inside the bench works on each word as the block accepts it, so
// the shadow state always moves in the same order as the block's own state.
module tree_path_distance_lca_test;
  import tpd_pkg::*;

  localparam int NODE_SPAN  = 65536;
  localparam int EDGE_SPAN  = 2 * NODE_SPAN;
  localparam int LEVELS     = 16;
  localparam int SETTLE     = 200;      // cycles allowed after the last word
  localparam int unsigned TIMEOUT_CYC = 40_000_000;

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_ready;
  item_t   item;
  logic    result_valid;
  logic    result_ready;
  result_t result;
  logic    cfg_valid;
  logic    cfg_ready;
  logic [15:0] cfg_data;

  tree_path_distance_lca dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the block's tree store
  // ---------------------------------------------------------------------------
  logic [15:0] sh_root;
  int unsigned sh_nodes;
  int unsigned sh_edges;
  bit          sh_built;
  // list links hold edge index + 1, zero ends the list
  int unsigned adj_head [NODE_SPAN];
  int unsigned adj_tail [NODE_SPAN];
  int unsigned e_target [EDGE_SPAN];
  logic [31:0] e_weight [EDGE_SPAN];
  int unsigned e_next   [EDGE_SPAN];
  int unsigned depth_of [NODE_SPAN];
  logic [47:0] dist_of  [NODE_SPAN];
  logic [15:0] lift     [LEVELS][NODE_SPAN];
  bit          seen     [NODE_SPAN];
  int unsigned stk_node [NODE_SPAN];
  int unsigned stk_link [NODE_SPAN];

  item_t   pending_items[$];
  result_t expected_results[$];

  int send_idle_pct;
  int recv_stall_pct;
  int fails;
  int words_sent, words_checked, queries_ok, queries_refused, builds_done;

  task automatic report(input string what);
    fails++;
    $display("mismatch @%0t: %s", $realtime, what);
  endtask

  function automatic void wipe_store();
    for (int i = 0; i < NODE_SPAN; i++) begin
      adj_head[i] = 0;
      adj_tail[i] = 0;
      depth_of[i] = 0;
      dist_of[i]  = '0;
      seen[i]     = 0;
    end
    sh_edges = 0;
    sh_built = 0;
  endfunction

  function automatic void link_edge(int unsigned src, int unsigned dst, logic [31:0] w);
    int unsigned idx;
    idx = sh_edges;
    e_target[idx] = dst;
    e_weight[idx] = w;
    e_next[idx]   = 0;
    if (adj_tail[src] == 0) adj_head[src] = idx + 1;
    else e_next[adj_tail[src] - 1] = idx + 1;
    adj_tail[src] = idx + 1;
    sh_edges = idx + 1;
  endfunction

  // depth-first walk in insertion order, keeping the first way into each node
  function automatic void walk_tree(int unsigned r);
    int unsigned sp, link, u, v, e;
    for (int i = 0; i < NODE_SPAN; i++) begin
      depth_of[i] = 0;
      dist_of[i]  = '0;
      seen[i]     = 0;
    end
    seen[r] = 1;
    depth_of[r] = 1;
    for (int k = 0; k < LEVELS; k++) lift[k][r] = r;
    stk_node[0] = r;
    stk_link[0] = adj_head[r];
    sp = 1;
    while (sp > 0) begin
      link = stk_link[sp-1];
      u    = stk_node[sp-1];
      if (link == 0) begin
        sp--;
      end else begin
        e = link - 1;
        stk_link[sp-1] = e_next[e];
        v = e_target[e];
        if (!seen[v]) begin
          seen[v] = 1;
          depth_of[v] = depth_of[u] + 1;
          dist_of[v]  = dist_of[u] + 48'(e_weight[e]);
          lift[0][v]  = u;
          for (int k = 1; k < LEVELS; k++) lift[k][v] = lift[k-1][lift[k-1][v]];
          if (sp < NODE_SPAN) begin
            stk_node[sp] = v;
            stk_link[sp] = adj_head[v];
            sp++;
          end
        end
      end
    end
    sh_built = 1;
  endfunction

  function automatic int unsigned common_ancestor(int unsigned a, int unsigned b);
    int unsigned u, v, gap, pu, pv;
    u = a;
    v = b;
    if (depth_of[u] < depth_of[v]) begin
      u = b;
      v = a;
    end
    gap = depth_of[u] - depth_of[v];
    for (int i = 0; i < LEVELS; i++)
      if (gap[i]) u = lift[i][u];
    if (u == v) return u;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      pu = lift[i][u];
      pv = lift[i][v];
      if (pu != pv) begin
        u = pu;
        v = pv;
      end
    end
    return lift[0][u];
  endfunction

  // works out the result word for one accepted item and updates the shadow
  function automatic result_t path_word(item_t it);
    result_t r;
    int unsigned l;
    r.path_length = '0;
    r.status = ST_OK;
    case (it.op)
      OP_CLEAR: begin
        if (it.node_count == 0 || it.node_count > NODE_SPAN) r.status = ST_BAD_NODE;
        else begin
          sh_nodes = it.node_count;
          wipe_store();
        end
      end
      OP_EDGE: begin
        if (it.node_a >= sh_nodes || it.node_b >= sh_nodes) r.status = ST_BAD_NODE;
        else if (sh_edges + 2 > EDGE_SPAN) r.status = ST_FULL;
        else begin
          link_edge(it.node_a, it.node_b, it.edge_length);
          link_edge(it.node_b, it.node_a, it.edge_length);
          sh_built = 0;
        end
      end
      OP_BUILD: begin
        if (sh_root >= sh_nodes) r.status = ST_BAD_NODE;
        else begin
          walk_tree(sh_root);
          builds_done++;
        end
      end
      default: begin
        if (it.node_a >= sh_nodes || it.node_b >= sh_nodes) r.status = ST_BAD_NODE;
        else if (!sh_built || !seen[it.node_a] || !seen[it.node_b]) r.status = ST_NOT_BUILT;
        else begin
          l = common_ancestor(it.node_a, it.node_b);
          r.path_length = dist_of[it.node_a] + dist_of[it.node_b] - 2 * dist_of[l];
        end
        if (r.status == ST_OK) queries_ok++;
        else queries_refused++;
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, driver and monitor
  // ---------------------------------------------------------------------------
  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // item driver: a word stays put until taken, then the next is offered
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        expected_results.push_back(path_word(item));
        words_sent++;
      end
      if (!item_valid || item_ready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          item <= pending_items.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: random back-pressure, in-order compare
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          report("result word with nothing expected");
        end else begin
          result_t want;
          want = expected_results.pop_front();
          if (result.status !== want.status)
            report($sformatf("status %0d, want %0d", result.status, want.status));
          if (result.path_length !== want.path_length)
            report($sformatf("path_length %0d, want %0d",
                             result.path_length, want.path_length));
          words_checked++;
        end
      end
      result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #(TIMEOUT_CYC * 12.0);
    $display("timeout with %0d words outstanding", expected_results.size());
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic void queue_word(op_t op, int unsigned a, int unsigned b,
                                     logic [31:0] w, int unsigned cnt);
    item_t t;
    t.op = op;
    t.node_a = a[15:0];
    t.node_b = b[15:0];
    t.edge_length = w;
    t.node_count = cnt[16:0];
    pending_items.push_back(t);
  endfunction

  // sender pauses here until every result is back, then lets the block settle
  task automatic drain();
    while (pending_items.size() > 0 || item_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_root(input logic [15:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sh_root = v;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_weight();
    case ($urandom_range(3))
      0: return 32'hFFFF_FFFF;
      1: return $urandom_range(0, 20);
      default: return $urandom;
    endcase
  endfunction

  // one random phase: tree over the given labels, build, queries
  task automatic tree_phase(input int unsigned cnt, input logic [15:0] root,
                            input int unsigned span);
    int unsigned labels[$];
    int unsigned x, a, b;
    bit fresh;
    drain();
    set_root(root);
    queue_word(OP_CLEAR, 0, 0, 0, cnt);
    // labels[0] is the root when the root is valid, so the tree is reachable
    if (root < cnt) labels.push_back(root);
    while (labels.size() < span) begin
      x = (cnt > 64) ? $urandom_range(cnt - 1) : $urandom_range(cnt - 1);
      fresh = 1;
      foreach (labels[i]) if (labels[i] == x) fresh = 0;
      if (fresh) labels.push_back(x);
      if (labels.size() >= cnt) break;
    end
    queue_word(OP_QUERY, labels[0], labels[labels.size()-1], 0, 0);
    // attach all but the last two labels; those stay unreached
    for (int i = 1; i < labels.size() - 2; i++) begin
      a = labels[$urandom_range(i - 1)];
      if ($urandom_range(1)) queue_word(OP_EDGE, a, labels[i], rand_weight(), 0);
      else queue_word(OP_EDGE, labels[i], a, rand_weight(), 0);
    end
    // spare edges close cycles; one self loop
    for (int i = 0; i < 3; i++)
      queue_word(OP_EDGE, labels[$urandom_range(labels.size() - 3)],
                 labels[$urandom_range(labels.size() - 3)], rand_weight(), 0);
    queue_word(OP_EDGE, labels[1], labels[1], $urandom, 0);
    queue_word(OP_EDGE, $urandom, $urandom, $urandom, 0);
    queue_word(OP_BUILD, 0, 0, 0, 0);
    for (int i = 0; i < 50; i++) begin
      case ($urandom_range(15))
        0: queue_word(OP_QUERY, $urandom, $urandom, $urandom, $urandom);
        1: queue_word(OP_CLEAR, 0, 0, 0, $urandom_range(1) ? 0 : $urandom_range(65537, 131071));
        default:
          queue_word(OP_QUERY, labels[$urandom_range(labels.size() - 1)],
                     labels[$urandom_range(labels.size() - 1)], $urandom, $urandom);
      endcase
    end
    // a late edge spoils the tables; the following queries are refused
    queue_word(OP_EDGE, labels[0], labels[labels.size()-1], $urandom, 0);
    for (int i = 0; i < 6; i++)
      queue_word(OP_QUERY, labels[$urandom_range(labels.size() - 1)], labels[0], 0, 0);
  endtask

  initial begin
    item_valid = 0;
    item = '0;
    result_ready = 0;
    cfg_valid = 0;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fails = 0;
    words_sent = 0;
    words_checked = 0;
    queries_ok = 0;
    queries_refused = 0;
    builds_done = 0;
    sh_root = 16'd1;
    sh_nodes = 0;
    for (int i = 0; i < NODE_SPAN; i++) begin
      adj_head[i] = 0;
      adj_tail[i] = 0;
      depth_of[i] = 0;
      dist_of[i] = '0;
      seen[i] = 0;
    end
    sh_edges = 0;
    sh_built = 0;
    rst = 1;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: everything before any clear is a bad index
    queue_word(OP_QUERY, 0, 0, 0, 0);
    queue_word(OP_EDGE, 0, 0, 1, 0);
    queue_word(OP_BUILD, 0, 0, 0, 0);
    queue_word(OP_CLEAR, 0, 0, 0, 0);
    queue_word(OP_CLEAR, 0, 0, 0, 17'h1FFFF);
    queue_word(OP_CLEAR, 0, 0, 0, 6);
    queue_word(OP_QUERY, 1, 2, 0, 0);          // before build
    queue_word(OP_EDGE, 1, 0, 32'hFFFF_FFFF, 0);
    queue_word(OP_EDGE, 1, 2, 0, 0);
    queue_word(OP_EDGE, 2, 3, 32'h8000_0001, 0);
    queue_word(OP_EDGE, 0, 3, 5, 0);           // closes a cycle
    queue_word(OP_EDGE, 4, 4, 9, 0);           // self loop, node 4 stays apart
    queue_word(OP_EDGE, 6, 0, 1, 0);           // endpoint out of range
    queue_word(OP_EDGE, 0, 16'hFFFF, 1, 0);
    queue_word(OP_BUILD, 0, 0, 0, 0);
    queue_word(OP_QUERY, 0, 3, 0, 0);
    queue_word(OP_QUERY, 3, 0, 0, 0);
    queue_word(OP_QUERY, 2, 2, 0, 0);
    queue_word(OP_QUERY, 1, 3, 0, 0);
    queue_word(OP_QUERY, 4, 1, 0, 0);          // unreached
    queue_word(OP_QUERY, 16'hFFFF, 1, 0, 0);
    queue_word(OP_QUERY, 5, 6, 0, 0);
    drain();
    set_root(16'd9);                            // root beyond the node count
    queue_word(OP_BUILD, 0, 0, 0, 0);
    queue_word(OP_QUERY, 0, 1, 0, 0);

    // random phases over every idling mix
    send_idle_pct = 0;  recv_stall_pct = 0;
    tree_phase(40, 16'd0, 40);
    send_idle_pct = 55; recv_stall_pct = 0;
    tree_phase(65536, 16'hFFFF, 60);
    send_idle_pct = 0;  recv_stall_pct = 55;
    tree_phase($urandom_range(12, 48), 16'd1, 48);
    send_idle_pct = 15; recv_stall_pct = 15;
    tree_phase(65536, 16'($urandom), 50);
    send_idle_pct = 55; recv_stall_pct = 0;
    tree_phase(3, 16'd2, 3);
    send_idle_pct = 0;  recv_stall_pct = 55;
    tree_phase(30, 16'($urandom_range(29)), 30);
    send_idle_pct = 15; recv_stall_pct = 15;
    tree_phase(20, 16'($urandom_range(19)), 20);
    drain();

    $display("covered %0d words (%0d checked): %0d builds, %0d answered queries,",
             words_sent, words_checked, builds_done, queries_ok);
    $display("%0d refused queries, bad indices, cycles, self loops and stale tables",
             queries_refused);
    if (fails == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
